FILE: rtl/core/wmap_pkg.sv
// Shared constants for the 16-to-8 window mapper.
// No dependencies; compile first.
package wmap_pkg;

  localparam int PIX_W          = 16;
  localparam int LEVEL_W        = 8;
  localparam int NUM_W          = PIX_W + LEVEL_W;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int PIXEL_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH   = 2'd2;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_MAP     = 1'b1;

  localparam logic [LEVEL_W-1:0] LEVEL_MIN = '0;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  localparam logic [PIX_W-1:0] WINDOW_HIGH_RST = '1;

endpackage

FILE: rtl/core/wmap_if.sv
// Valid/ready channel interfaces for pixel in, level out and register writes.
// Depends on wmap_pkg.
interface wmap_in_if;
  import wmap_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;
  modport source (output valid, operation, pixel, frame_start, input ready);
  modport sink   (input valid, operation, pixel, frame_start, output ready);
endinterface

interface wmap_out_if;
  import wmap_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  modport source (output valid, level, input ready);
  modport sink   (input valid, level, output ready);
endinterface

interface wmap_cfg_if;
  import wmap_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/window_map_16_to_8.sv
// Window mapper: 16-bit pixels to 8-bit levels through a linear window; a measure
// beat updates the frame minimum and maximum, kept in a one-entry memory read and
// written back, and a map beat yields one level. One beat is in work at a time:
// a measure beat goes from lookup back to idle, a map beat that clamps to 0 or 255
// goes to finish, and a map beat inside the window passes the bit-serial divider first.
// Depends on wmap_pkg, wmap_if and wmap_div.
module window_map_16_to_8 #(
  parameter int PIXEL_BITS = wmap_pkg::PIXEL_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  wmap_in_if.sink    in_chan,
  wmap_out_if.source out_chan,
  wmap_cfg_if.sink   cfg_chan
);
  import wmap_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_DIVIDE, ST_FINISH} state_t;

  localparam logic [PIXEL_BITS-1:0] MIN_RST = '1;
  localparam logic [PIXEL_BITS-1:0] MAX_RST = '0;

  state_t state_r;

  logic             manual_r;
  logic [PIX_W-1:0] win_low_r;
  logic [PIX_W-1:0] win_high_r;

  logic                    op_r;
  logic                    fs_r;
  logic [PIXEL_BITS-1:0]   pix_r;
  logic [LEVEL_W-1:0]      res_r;
  logic [LEVEL_W-1:0]      out_level_r;
  logic                    out_valid_r;

  logic [2*PIXEL_BITS-1:0] stat_mem [1];
  logic [2*PIXEL_BITS-1:0] mem_rd_r;
  logic                    stat_vld_r;
  logic                    mem_re;
  logic                    mem_we;
  logic [2*PIXEL_BITS-1:0] mem_wdata;

  logic [PIXEL_BITS-1:0] cur_min;
  logic [PIXEL_BITS-1:0] cur_max;
  logic [PIXEL_BITS-1:0] new_min;
  logic [PIXEL_BITS-1:0] new_max;
  logic [PIX_W-1:0]      lo;
  logic [PIX_W-1:0]      hi;
  logic [PIX_W-1:0]      pix_ext;
  logic [PIX_W-1:0]      offs;
  logic [NUM_W-1:0]      num;
  logic [PIX_W-1:0]      span;
  logic                  at_high;
  logic                  below_low;

  logic                  in_fire;
  logic                  div_start;
  logic                  div_done;
  logic [LEVEL_W-1:0]    div_quot;
  logic                  out_free;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.level = out_level_r;
  assign out_free       = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      manual_r   <= 1'b0;
      win_low_r  <= '0;
      win_high_r <= WINDOW_HIGH_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_MANUAL_WINDOW: manual_r   <= cfg_chan.data[0];
        REG_WINDOW_LOW:    win_low_r  <= cfg_chan.data[PIX_W-1:0];
        REG_WINDOW_HIGH:   win_high_r <= cfg_chan.data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_min   = stat_vld_r ? mem_rd_r[PIXEL_BITS-1:0] : MIN_RST;
    cur_max   = stat_vld_r ? mem_rd_r[2*PIXEL_BITS-1:PIXEL_BITS] : MAX_RST;
    new_min   = fs_r ? pix_r : ((pix_r < cur_min) ? pix_r : cur_min);
    new_max   = fs_r ? pix_r : ((pix_r > cur_max) ? pix_r : cur_max);
    mem_wdata = {new_max, new_min};
    mem_re    = in_fire;
    mem_we    = (state_r == ST_LOOKUP) && (op_r == OP_MEASURE);

    lo        = manual_r ? win_low_r  : PIX_W'(cur_min);
    hi        = manual_r ? win_high_r : PIX_W'(cur_max);
    pix_ext   = PIX_W'(pix_r);
    at_high   = pix_ext >= hi;
    below_low = pix_ext < lo;
    offs      = pix_ext - lo;
    span      = hi - lo;
    num       = (NUM_W'(offs) << LEVEL_W) - NUM_W'(offs);
    div_start = (state_r == ST_LOOKUP) && (op_r == OP_MAP) && !at_high && !below_low;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stat_mem[0] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_r <= stat_mem[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_vld_r <= 1'b0;
    end else if (mem_we) begin
      stat_vld_r <= 1'b1;
    end
  end

  wmap_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (span),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_chan.ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            op_r    <= in_chan.operation;
            fs_r    <= in_chan.frame_start;
            pix_r   <= in_chan.pixel[PIXEL_BITS-1:0];
            state_r <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (op_r == OP_MEASURE) begin
            state_r <= ST_IDLE;
          end else if (at_high) begin
            res_r   <= LEVEL_MAX;
            state_r <= ST_FINISH;
          end else if (below_low) begin
            res_r   <= LEVEL_MIN;
            state_r <= ST_FINISH;
          end else begin
            state_r <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            res_r   <= div_quot;
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_level_r <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/wmap_div.sv
// Restoring divider, one quotient bit per cycle, for quotients below 2^LEVEL_W.
// Depends on wmap_pkg.
module wmap_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wmap_pkg::NUM_W-1:0]   num,
  input  logic [wmap_pkg::PIX_W-1:0]   den,
  output logic                         done,
  output logic [wmap_pkg::LEVEL_W-1:0] quot
);
  import wmap_pkg::*;

  localparam int CNT_W = $clog2(LEVEL_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] dsh_r;
  logic [LEVEL_W-1:0] q_r;
  logic [NUM_W:0]   diff;
  logic             ge;

  always_comb begin
    diff = {1'b0, rem_r} - {1'b0, dsh_r};
    ge   = !diff[NUM_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(LEVEL_W - 1);
        rem_r  <= num;
        dsh_r  <= NUM_W'(den) << (LEVEL_W - 1);
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= diff[NUM_W-1:0];
        end
        q_r   <= {q_r[LEVEL_W-2:0], ge};
        dsh_r <= dsh_r >> 1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for window_map_16_to_8: streams measure and map beats, writes the
// window registers between phases and checks every level against a built-in predictor.
// Depends on wmap_pkg, wmap_if and the window_map_16_to_8 RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wmap_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pixel_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wmap_in_if  in_chan();
  wmap_out_if out_chan();
  wmap_cfg_if cfg_chan();

  window_map_16_to_8 u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  pixel_beat_t        beat_q[$];
  logic [LEVEL_W-1:0] level_q[$];

  logic             mode_manual;
  logic [PIX_W-1:0] win_lo;
  logic [PIX_W-1:0] win_hi;
  logic [PIX_W-1:0] frame_min;
  logic [PIX_W-1:0] frame_max;

  int idle_odds = 0;
  int gap_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit in_fire = 1'b0;
  bit failed = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [LEVEL_W-1:0] level_for(logic [PIX_W-1:0] p,
                                                   logic [PIX_W-1:0] lo,
                                                   logic [PIX_W-1:0] hi);
    int unsigned scaled;
    int unsigned span;
    if (p >= hi) return LEVEL_MAX;
    if (p < lo) return LEVEL_MIN;
    span = hi - lo;
    scaled = (p - lo) * LEVEL_MAX;
    return LEVEL_W'(scaled / span);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(logic [PIX_W-1:0] lo, logic [PIX_W-1:0] hi);
    case ($urandom_range(0, 7))
      0: return PIX_W'($urandom);
      1: return lo;
      2: return hi;
      3: return $urandom_range(0, 1) ? '1 : '0;
      default: return PIX_W'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic push_beat(logic op, logic [PIX_W-1:0] pix, logic fs);
    pixel_beat_t b;
    b.op = op;
    b.pixel = pix;
    b.frame_start = fs;
    beat_q.push_back(b);
  endtask

  // Two-pass frames with random content, mixed with stray beats and broken frames.
  task automatic add_frames(int n_items, bit use_window, logic [PIX_W-1:0] lo,
                            logic [PIX_W-1:0] hi);
    int left;
    int fsize;
    logic [PIX_W-1:0] f_lo;
    logic [PIX_W-1:0] f_hi;
    logic [PIX_W-1:0] frame[$];
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        push_beat($urandom_range(0, 1) ? OP_MAP : OP_MEASURE, PIX_W'($urandom),
                  1'($urandom_range(0, 1)));
        left--;
      end else begin
        if (use_window) begin
          f_lo = lo;
          f_hi = hi;
        end else begin
          f_lo = PIX_W'($urandom_range(0, 65535));
          if ($urandom_range(0, 2) == 0)
            f_hi = (f_lo > 65000) ? '1 : f_lo + PIX_W'($urandom_range(1, 400));
          else
            f_hi = PIX_W'($urandom_range(f_lo, 65535));
        end
        frame.delete();
        fsize = $urandom_range(1, 20);
        for (int i = 0; i < fsize; i++) frame.push_back(pick_pixel(f_lo, f_hi));
        for (int i = 0; i < fsize; i++)
          push_beat(OP_MEASURE, frame[i], (i == 0) && ($urandom_range(0, 7) != 0));
        for (int i = 0; i < fsize; i++)
          push_beat(OP_MAP, $urandom_range(0, 3) == 0 ? pick_pixel(f_lo, f_hi) : frame[i],
                    1'($urandom_range(0, 1)));
        left -= 2 * fsize;
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!(cfg_chan.valid && cfg_chan.ready));
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk); while (beat_q.size() != 0 || in_chan.valid || level_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixel driver.
  always @(negedge clk) begin
    pixel_beat_t b;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (in_chan.valid && !in_fire) begin
      // hold the pending beat
    end else if (gap_left > 0) begin
      gap_left--;
      in_chan.valid <= 1'b0;
    end else if (beat_q.size() != 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      gap_left = $urandom_range(0, 12);
      in_chan.valid <= 1'b0;
    end else if (beat_q.size() != 0) begin
      b = beat_q.pop_front();
      in_chan.operation   <= b.op;
      in_chan.pixel       <= b.pixel;
      in_chan.frame_start <= b.frame_start;
      in_chan.valid       <= 1'b1;
    end else begin
      in_chan.valid <= 1'b0;
    end
  end

  // Level receiver.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      stall_left = $urandom_range(0, 12);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Predict, check and watch for a stalled run.
  always @(posedge clk) begin
    logic [LEVEL_W-1:0] want;
    if (!rst_n) begin
      in_fire      <= 1'b0;
      quiet_cycles <= 0;
      mode_manual  = 1'b0;
      win_lo       = '0;
      win_hi       = WINDOW_HIGH_RST;
      frame_min    = '1;
      frame_max    = '0;
    end else begin
      in_fire <= in_chan.valid && in_chan.ready;
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          REG_MANUAL_WINDOW: mode_manual = cfg_chan.data[0];
          REG_WINDOW_LOW:    win_lo = cfg_chan.data;
          REG_WINDOW_HIGH:   win_hi = cfg_chan.data;
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        if (in_chan.operation == OP_MEASURE) begin
          if (in_chan.frame_start) begin
            frame_min = in_chan.pixel;
            frame_max = in_chan.pixel;
          end else begin
            if (in_chan.pixel < frame_min) frame_min = in_chan.pixel;
            if (in_chan.pixel > frame_max) frame_max = in_chan.pixel;
          end
        end else if (mode_manual) begin
          level_q.push_back(level_for(in_chan.pixel, win_lo, win_hi));
        end else begin
          level_q.push_back(level_for(in_chan.pixel, frame_min, frame_max));
        end
      end
      if (out_chan.valid && out_chan.ready) begin
        if (level_q.size() == 0) begin
          $error("level: expected none, actual %0d", out_chan.level);
          failed = 1'b1;
        end else begin
          want = level_q.pop_front();
          if (out_chan.level !== want) begin
            $error("level: expected %0d, actual %0d", want, out_chan.level);
            failed = 1'b1;
          end
        end
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("window_map_16_to_8 verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    in_chan.valid       = 1'b0;
    in_chan.operation   = OP_MEASURE;
    in_chan.pixel       = '0;
    in_chan.frame_start = 1'b0;
    out_chan.ready      = 1'b0;
    cfg_chan.valid      = 1'b0;
    cfg_chan.index      = REG_MANUAL_WINDOW;
    cfg_chan.data       = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset window: map before measure, frame_start on map, edges, flat window.
    idle_odds = 12;
    push_beat(OP_MAP, 16'd0, 1'b0);
    push_beat(OP_MAP, 16'd65535, 1'b0);
    push_beat(OP_MAP, 16'd12345, 1'b1);
    push_beat(OP_MEASURE, 16'd1000, 1'b1);
    push_beat(OP_MEASURE, 16'd3000, 1'b0);
    push_beat(OP_MEASURE, 16'd2000, 1'b0);
    push_beat(OP_MAP, 16'd999, 1'b0);
    push_beat(OP_MAP, 16'd1000, 1'b0);
    push_beat(OP_MAP, 16'd2000, 1'b1);
    push_beat(OP_MAP, 16'd2999, 1'b0);
    push_beat(OP_MAP, 16'd3000, 1'b0);
    push_beat(OP_MEASURE, 16'd65535, 1'b1);
    push_beat(OP_MEASURE, 16'd0, 1'b0);
    push_beat(OP_MAP, 16'd1, 1'b0);
    push_beat(OP_MAP, 16'd32768, 1'b0);
    push_beat(OP_MAP, 16'd65534, 1'b0);
    push_beat(OP_MEASURE, 16'd777, 1'b1);
    push_beat(OP_MAP, 16'd776, 1'b0);
    push_beat(OP_MAP, 16'd777, 1'b0);
    push_beat(OP_MAP, 16'd778, 1'b0);
    add_frames(150, 1'b0, '0, '1);
    settle();

    // Manual window; measure beats still move the frame bounds.
    write_reg(REG_MANUAL_WINDOW, 16'd1);
    write_reg(REG_WINDOW_LOW, 16'd1000);
    write_reg(REG_WINDOW_HIGH, 16'd3000);
    idle_odds = 0;
    push_beat(OP_MEASURE, 16'd5, 1'b1);
    push_beat(OP_MEASURE, 16'd6, 1'b0);
    push_beat(OP_MAP, 16'd999, 1'b0);
    push_beat(OP_MAP, 16'd1000, 1'b0);
    push_beat(OP_MAP, 16'd2999, 1'b0);
    push_beat(OP_MAP, 16'd3000, 1'b0);
    add_frames(150, 1'b1, 16'd1000, 16'd3000);
    settle();

    write_reg(REG_WINDOW_LOW, 16'd0);
    write_reg(REG_WINDOW_HIGH, 16'd65535);
    idle_odds = 6;
    add_frames(150, 1'b1, 16'd0, 16'd65535);
    settle();

    // Empty and inverted windows.
    write_reg(REG_WINDOW_LOW, 16'd5000);
    write_reg(REG_WINDOW_HIGH, 16'd5000);
    idle_odds = 20;
    add_frames(60, 1'b1, 16'd4990, 16'd5010);
    settle();
    write_reg(REG_WINDOW_LOW, 16'd60000);
    write_reg(REG_WINDOW_HIGH, 16'd100);
    add_frames(60, 1'b1, 16'd50, 16'd60100);
    settle();

    // Unmapped index is dropped; only bit 0 of the mode register counts.
    write_reg(REG_UNMAPPED, 16'hFFFF);
    write_reg(REG_MANUAL_WINDOW, 16'hFFFE);
    idle_odds = 10;
    add_frames(120, 1'b0, '0, '1);
    settle();

    write_reg(REG_MANUAL_WINDOW, 16'd1);
    write_reg(REG_WINDOW_LOW, 16'd20000);
    write_reg(REG_WINDOW_HIGH, 16'd20255);
    idle_odds = 4;
    add_frames(80, 1'b1, 16'd19900, 16'd20400);
    settle();

    // Last stretch at full rate.
    write_reg(REG_MANUAL_WINDOW, 16'd0);
    idle_odds = 0;
    add_frames(100, 1'b0, '0, '1);
    settle();

    if (!failed && level_q.size() == 0) begin
      $display("window_map_16_to_8 verification clean");
    end else begin
      $display("window_map_16_to_8 verification failed");
    end
    $finish;
  end

endmodule
